FILE: rtl/scrs_pkg.sv
// Shared types and constants of the small coefficient rejection sampler.
`default_nettype none

package scrs_pkg;

	// Sequencer states.
	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// Register indexes of the configuration port.
	localparam logic CFG_IDX_MODE   = 1'b0;
	localparam logic CFG_IDX_TARGET = 1'b1;

	// Sampling modes.
	localparam logic MODE_ETA1 = 1'b0;
	localparam logic MODE_ETA2 = 1'b1;

	localparam logic [8:0] TARGET_RESET = 9'd256;

	// Rejection bounds.
	localparam logic [7:0] ETA1_BOUND  = 8'd243;
	localparam logic [3:0] ETA2_REJECT = 4'hF;

	// Reciprocals for division by three (shift 9) and by five (shift 10).
	localparam logic [7:0] RECIP3 = 8'd171;
	localparam logic [7:0] RECIP5 = 8'd205;

	// Last step index of each mode: five trits or two nibbles.
	localparam logic [2:0] LAST_DIG_ETA1 = 3'd4;
	localparam logic [2:0] LAST_DIG_ETA2 = 3'd1;

	// Quotient and remainder from the shared digit unit.
	typedef struct packed {
		logic [7:0] quot;
		logic [2:0] rem;
	} digit_res_t;

endpackage : scrs_pkg

`default_nettype wire

FILE: rtl/scrs_digit_unit.sv
// Shared divide-by-constant unit: quotient and remainder by three or by five.
`default_nettype none

module scrs_digit_unit (
	input  wire logic                    eta_mode,
	input  wire logic [7:0]              operand,
	output scrs_pkg::digit_res_t         res
);
	import scrs_pkg::*;

	logic [7:0]  recip;
	logic [15:0] prod;
	logic [7:0]  quot;
	logic [9:0]  back;
	logic [7:0]  diff;

	// One small multiplier serves both moduli; the reciprocal is exact for the operand range.
	always_comb begin
		recip = (eta_mode == MODE_ETA2) ? RECIP5 : RECIP3;
		prod  = {8'd0, operand} * {8'd0, recip};
		if (eta_mode == MODE_ETA2) begin
			quot = {2'd0, prod[15:10]};
			back = {2'd0, quot} + {quot, 2'd0};
		end else begin
			quot = {1'b0, prod[15:9]};
			back = {2'd0, quot} + {1'b0, quot, 1'b0};
		end
		diff      = operand - back[7:0];
		res.quot  = quot;
		res.rem   = diff[2:0];
	end

endmodule : scrs_digit_unit

`default_nettype wire

FILE: rtl/small_coefficient_rejection_sampler.sv
// Top level of the small coefficient rejection sampler: sequencer, counter and output register.
`default_nettype none

// Channel   Handshake                 Payload
// in        in_valid / in_stall       rand_byte, start_new, end_of_buffer
// out       out_valid / out_stall     coefficient, coef_index, coef_valid,
//                                     produced_count, last_of_run
// cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// An item is accepted while the sequencer is idle, then takes one step per digit
// in the shared divide-by-constant unit: five steps in eta-one mode, two in eta-two mode.
// Each step waits while the output register holds a result that is stalled.
// Reset clears the count, the sequencer and the output valid; eta_mode resets to
// eta one and target_count to 256. The configuration port is always ready.

module small_coefficient_rejection_sampler #(
	parameter int MAX_COEFS = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [7:0]        rand_byte,
	input  wire logic              start_new,
	input  wire logic              end_of_buffer,

	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic signed [2:0]      coefficient,
	output logic [7:0]             coef_index,
	output logic                   coef_valid,
	output logic [8:0]             produced_count,
	output logic                   last_of_run,

	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              cfg_index,
	input  wire logic [8:0]        cfg_data
);
	import scrs_pkg::*;

	// The count is nine bits wide, so any cap of 511 or more never binds.
	localparam int           LimCapInt = (MAX_COEFS > 511) ? 511 : MAX_COEFS;
	localparam logic [8:0]   LIM_CAP   = LimCapInt[8:0];

	// Configuration registers.
	logic       eta_mode_q;
	logic [8:0] target_q;

	// Sequencer state and the item under work.
	state_t     state_q, state_d;
	logic [7:0] byte_q;
	logic [7:0] trit_q;
	logic       eob_q;
	logic [2:0] dig_q;
	logic       emitted_q;
	logic [8:0] produced_q;

	// Output register.
	logic              out_valid_q;
	logic signed [2:0] coef_q;
	logic [7:0]        idx_q;
	logic              cvalid_q;
	logic [8:0]        count_q;
	logic              last_q;

	// Step control.
	logic       accept;
	logic       out_free;
	logic       step_go;
	logic [8:0] lim;
	logic [8:0] prod_inc;
	logic [7:0] operand;
	logic       step_ok;
	logic       emit;
	logic       more;
	logic       last_step;
	logic       status;
	logic signed [2:0] coef_val;
	digit_res_t dres;

	scrs_digit_unit u_digit (
		.eta_mode (eta_mode_q),
		.operand  (operand),
		.res      (dres)
	);

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eta_mode_q <= MODE_ETA1;
			target_q   <= TARGET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IDX_MODE:   eta_mode_q <= cfg_data[0];
				CFG_IDX_TARGET: target_q   <= cfg_data;
				default:        ;
			endcase
		end
	end

	// Next state and step decisions. A step runs only when the output register
	// can take a result, so the digit walk never outruns the consumer.
	always_comb begin
		lim      = (target_q > LIM_CAP) ? LIM_CAP : target_q;
		prod_inc = produced_q + 9'd1;

		if (eta_mode_q == MODE_ETA2) begin
			operand   = (dig_q == 3'd0) ? {4'd0, byte_q[3:0]} : {4'd0, byte_q[7:4]};
			step_ok   = (operand[3:0] != ETA2_REJECT);
			last_step = (dig_q == LAST_DIG_ETA2);
			more      = (dig_q == 3'd0) && (byte_q[7:4] != ETA2_REJECT) && (prod_inc < lim);
			coef_val  = 3'sd2 - $signed(dres.rem);
		end else begin
			operand   = trit_q;
			step_ok   = (byte_q < ETA1_BOUND);
			last_step = (dig_q == LAST_DIG_ETA1);
			more      = (dig_q != LAST_DIG_ETA1) && (prod_inc < lim);
			coef_val  = (dres.rem == 3'd2) ? -3'sd1 : $signed(dres.rem);
		end

		step_go = (state_q == ST_RUN) && out_free;
		emit    = step_go && step_ok && (produced_q < lim);
		// Nothing came out of this item and it closes the buffer: report the count.
		status  = step_go && last_step && !emitted_q && !emit && eob_q;

		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (step_go && last_step) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			produced_q <= '0;
			emitted_q  <= 1'b0;
			dig_q      <= '0;
		end else if (accept) begin
			if (start_new) begin
				produced_q <= '0;
			end
			emitted_q <= 1'b0;
			dig_q     <= '0;
		end else if (step_go) begin
			dig_q <= dig_q + 3'd1;
			if (emit) begin
				produced_q <= prod_inc;
				emitted_q  <= 1'b1;
			end
		end
	end

	// Item payload; the trit register walks down by one division per step.
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= rand_byte;
			trit_q <= rand_byte;
			eob_q  <= end_of_buffer;
		end else if (step_go) begin
			trit_q <= dres.quot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit || status) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			coef_q   <= coef_val;
			idx_q    <= produced_q[7:0];
			cvalid_q <= 1'b1;
			count_q  <= prod_inc;
			last_q   <= !more;
		end else if (status) begin
			coef_q   <= 3'sd0;
			idx_q    <= 8'd0;
			cvalid_q <= 1'b0;
			count_q  <= produced_q;
			last_q   <= 1'b1;
		end
	end

	assign out_valid      = out_valid_q;
	assign coefficient    = coef_q;
	assign coef_index     = idx_q;
	assign coef_valid     = cvalid_q;
	assign produced_count = count_q;
	assign last_of_run    = last_q;

	// A real coefficient's count is always one past its index.
	a_count_follows_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && cvalid_q |-> count_q[7:0] == idx_q + 8'd1)
		else $error("produced_count does not follow coef_index");

	// A status result is a zero coefficient that closes the item.
	a_status_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !cvalid_q |-> last_q && coef_q == 3'sd0 && idx_q == 8'd0)
		else $error("malformed status result");

	// The digit walk never passes the last step of its mode.
	a_dig_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> dig_q <= ((eta_mode_q == MODE_ETA2) ? LAST_DIG_ETA2
		                                                        : LAST_DIG_ETA1))
		else $error("digit step out of range");

	// A result is never loaded over a stalled one.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !emit && !status)
		else $error("output register overwritten while stalled");

endmodule : small_coefficient_rejection_sampler

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for the small coefficient rejection sampler.
`timescale 1ns / 1ps

module tb_top;

	import scrs_pkg::*;

	localparam int MAX_COEFS = 256;

	// Cycles allowed after the last expected result before the block is taken as idle.
	// An item that yields nothing still occupies the block until its last digit step.
	localparam int IDLE_SETTLE = 12;

	// Cycles without any accepted item on any channel before the run is abandoned.
	localparam int QUIET_LIMIT = 5000;

	// Input items sent in each phase of the random buffer test.
	localparam int PHASE_ITEMS = 49;

	// One expected output item, laid out like the output ports.
	typedef struct packed {
		logic signed [2:0] coef;
		logic [7:0]        idx;
		logic              real_coef;
		logic [8:0]        count;
		logic              last;
	} coef_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [7:0]        rand_byte = 8'd0;
	logic              start_new = 1'b0;
	logic              end_of_buffer = 1'b0;

	logic              out_valid;
	logic              out_stall = 1'b0;
	logic signed [2:0] coefficient;
	logic [7:0]        coef_index;
	logic              coef_valid;
	logic [8:0]        produced_count;
	logic              last_of_run;

	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic              cfg_index = CFG_IDX_MODE;
	logic [8:0]        cfg_data = 9'd0;

	// Predictor state: the mode and target as last written, and the running count.
	logic       pm_mode = MODE_ETA1;
	logic [8:0] pm_target = TARGET_RESET;
	logic [8:0] pm_count = 9'd0;

	// Coefficients (and status items) that the block still owes us, oldest first.
	coef_rec_t pending_coefs[$];

	int fault_count = 0;
	int quiet_cycles = 0;

	always #5 clk = ~clk;

	small_coefficient_rejection_sampler #(
		.MAX_COEFS(MAX_COEFS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rand_byte(rand_byte),
		.start_new(start_new),
		.end_of_buffer(end_of_buffer),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.coefficient(coefficient),
		.coef_index(coef_index),
		.coef_valid(coef_valid),
		.produced_count(produced_count),
		.last_of_run(last_of_run),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Appends one real coefficient to the expected stream and advances the count.
	task automatic push_coef(input logic signed [2:0] c);
		coef_rec_t r;
		r.coef = c;
		r.idx = pm_count[7:0];
		r.real_coef = 1'b1;
		pm_count = pm_count + 9'd1;
		r.count = pm_count;
		r.last = 1'b0;
		pending_coefs.push_back(r);
	endtask

	// Works out what one accepted byte produces and queues it. The start flag
	// clears the count before the byte is looked at. The effective limit is the
	// smaller of the target and the array size.
	task automatic sample_byte(input logic [7:0] b, input logic s, input logic e);
		int lim;
		int made;
		int d;
		int h;
		logic [7:0] t;
		logic [3:0] nib;
		coef_rec_t status;
		if (s)
			pm_count = 9'd0;
		lim = (int'(pm_target) > MAX_COEFS) ? MAX_COEFS : int'(pm_target);
		made = 0;
		if (pm_mode == MODE_ETA1) begin
			// Base-3 digits, least significant first: 0, 1, 2 map to 0, 1, -1.
			if (b < ETA1_BOUND) begin
				t = b;
				for (d = 0; d < 5 && int'(pm_count) < lim; d++) begin
					push_coef((t % 3 == 2) ? 3'sb111 : 3'(t % 3));
					made++;
					t = t / 3;
				end
			end
		end else begin
			// Low nibble first; a nibble of all ones is thrown away.
			for (h = 0; h < 2; h++) begin
				nib = (h == 0) ? b[3:0] : b[7:4];
				if (nib != ETA2_REJECT && int'(pm_count) < lim) begin
					push_coef(3'(2 - int'(nib % 5)));
					made++;
				end
			end
		end
		if (made == 0) begin
			// Nothing came out: only the end of a buffer earns a status item.
			if (e) begin
				status = '0;
				status.count = pm_count;
				status.last = 1'b1;
				pending_coefs.push_back(status);
			end
		end else begin
			pending_coefs[pending_coefs.size() - 1].last = 1'b1;
		end
	endtask

	// Sender idle time: mostly none, sometimes a few cycles, rarely a long pause.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 2);
		else if (r < 97)
			return $urandom_range(3, 6);
		return $urandom_range(10, 40);
	endfunction

	// Offers one item and holds it until the block takes it. Valid stays high when no
	// gap follows, so the caller must send again right away or drain.
	task automatic send_byte(input logic [7:0] b, input logic s, input logic e);
		int gap;
		in_valid <= 1'b1;
		rand_byte <= b;
		start_new <= s;
		end_of_buffer <= e;
		do
			@(posedge clk);
		while (in_stall);
		sample_byte(b, s, e);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops sending and waits until every owed item has come and the block has settled.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_coefs.size() != 0)
			@(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	// Writes the mode and then the target back to back; only called when idle.
	task automatic set_config(input logic mode, input logic [8:0] target);
		int i;
		for (i = 0; i < 2; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= (i == 0) ? CFG_IDX_MODE : CFG_IDX_TARGET;
			cfg_data <= (i == 0) ? {8'd0, mode} : target;
			do
				@(posedge clk);
			while (!cfg_ready);
			if (i == 0)
				pm_mode = mode;
			else
				pm_target = target;
		end
		cfg_valid <= 1'b0;
	endtask

	// Reset values in use: eta-one mode, target of 256. Covers the smallest byte, the
	// largest accepted byte, a rejected byte at the end of a buffer (status item)
	// and a rejected byte that gives nothing at all.
	task automatic test_reset_defaults();
		send_byte(8'd0, 1'b1, 1'b0);
		send_byte(8'd242, 1'b0, 1'b0);
		send_byte(8'd243, 1'b0, 1'b1);
		send_byte(8'd255, 1'b0, 1'b0);
	endtask

	// Eta-two mode: both nibbles good, both rejected, one of each, residues zero and four.
	task automatic test_eta2_nibbles();
		drain();
		set_config(MODE_ETA2, TARGET_RESET);
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b1);
		send_byte(8'hF0, 1'b0, 1'b0);
		send_byte(8'h0F, 1'b0, 1'b1);
		send_byte(8'h4E, 1'b0, 1'b0);
		send_byte(8'h59, 1'b1, 1'b1);
	endtask

	// The count limit: reaching a small target mid-byte, the status item once the
	// limit holds, a zero target, an oversized target clipped to the array size,
	// and a target of one that cuts a byte off after its first trit.
	task automatic test_count_limit();
		drain();
		set_config(MODE_ETA1, 9'd7);
		send_byte(8'd121, 1'b1, 1'b0);
		send_byte(8'd0, 1'b0, 1'b0);
		send_byte(8'd100, 1'b0, 1'b1);
		send_byte(8'd200, 1'b0, 1'b0);
		drain();
		set_config(MODE_ETA2, 9'd0);
		send_byte(8'h00, 1'b1, 1'b1);
		send_byte(8'h33, 1'b0, 1'b0);
		drain();
		set_config(MODE_ETA2, 9'h1FF);
		send_byte(8'h21, 1'b1, 1'b1);
		drain();
		set_config(MODE_ETA1, 9'd1);
		send_byte(8'h00, 1'b1, 1'b0);
	endtask

	// Random buffers under a series of settings. A buffer mostly opens with a start
	// flag and closes with an end mark; large targets get long buffers and often
	// keep the count across buffers so the limit is hit. Now and then the sender
	// stops until everything owed has come out.
	task automatic test_random_buffers();
		logic       modes[8] = '{MODE_ETA1, MODE_ETA2, MODE_ETA1, MODE_ETA2,
		                         MODE_ETA1, MODE_ETA2, MODE_ETA1, MODE_ETA2};
		logic [8:0] targets[8] = '{9'd256, 9'd256, 9'd511, 9'd20,
		                           9'd0, 9'd1, 9'd37, 9'd300};
		int p;
		int sent;
		int len;
		int j;
		bit big;
		logic [7:0] b;
		logic s;
		logic e;
		for (p = 0; p < 8; p++) begin
			drain();
			set_config(modes[p], targets[p]);
			big = targets[p] >= 9'd256;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				len = big ? $urandom_range(20, 70) : $urandom_range(1, 12);
				// The last buffer of a phase is cut to the phase's share of items.
				if (len > PHASE_ITEMS - sent)
					len = PHASE_ITEMS - sent;
				for (j = 0; j < len; j++) begin
					b = 8'($urandom_range(0, 255));
					// Push a fair share of bytes into the rejected ranges.
					if ($urandom_range(0, 99) < 15) begin
						if (modes[p] == MODE_ETA1)
							b = 8'($urandom_range(int'(ETA1_BOUND), 255));
						else if ($urandom_range(0, 1) == 1)
							b[3:0] = ETA2_REJECT;
						else
							b[7:4] = ETA2_REJECT;
					end
					if (j == 0)
						s = $urandom_range(0, 99) < (big ? 50 : 85);
					else
						s = $urandom_range(0, 99) < 3;
					e = (j == len - 1) || ($urandom_range(0, 99) < 3);
					send_byte(b, s, e);
					sent++;
				end
				if ($urandom_range(0, 5) == 0)
					drain();
			end
		end
	endtask

	// The receiver stalls in runs: often not at all for a while, mostly briefly,
	// and once in a while for a long stretch.
	int stall_hold = 0;
	always @(posedge clk) begin : drive_out_stall
		int r;
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				out_stall <= 1'b0;
				stall_hold <= $urandom_range(0, 8);
			end else if (r < 50) begin
				out_stall <= 1'b0;
				stall_hold <= $urandom_range(30, 60);
			end else if (r < 85) begin
				out_stall <= 1'b1;
				stall_hold <= $urandom_range(0, 2);
			end else if (r < 97) begin
				out_stall <= 1'b1;
				stall_hold <= $urandom_range(3, 6);
			end else begin
				out_stall <= 1'b1;
				stall_hold <= $urandom_range(10, 30);
			end
		end
	end

	// Every item taken from the output is matched against the oldest owed item.
	always @(posedge clk) begin : check_coefs
		coef_rec_t want;
		coef_rec_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = {coefficient, coef_index, coef_valid, produced_count, last_of_run};
			if (pending_coefs.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("%0t: unexpected item coef %0d idx %0d real %0b count %0d last %0b",
						$realtime, got.coef, got.idx, got.real_coef, got.count, got.last);
			end else begin
				want = pending_coefs.pop_front();
				if (got.coef !== want.coef || got.idx !== want.idx ||
				    got.real_coef !== want.real_coef || got.count !== want.count ||
				    got.last !== want.last) begin
					fault_count++;
					if (fault_count <= 10)
						$display({"%0t: mismatch, expected coef %0d idx %0d real %0b count %0d ",
							"last %0b, got coef %0d idx %0d real %0b count %0d last %0b"},
							$realtime, want.coef, want.idx, want.real_coef, want.count,
							want.last, got.coef, got.idx, got.real_coef, got.count, got.last);
				end
			end
		end
	end

	// Ends a hung run: counts cycles in which no channel moves an item.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_eta2_nibbles();
		test_count_limit();
		test_random_buffers();
		drain();
		if (fault_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: files.f
rtl/scrs_pkg.sv
rtl/scrs_digit_unit.sv
rtl/small_coefficient_rejection_sampler.sv
test/tb_top.sv
